### hw/rtl/abpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abpb_pkg;

    // Blend modes, as held in the blend_mode register
    typedef enum logic [1:0] {
        MODE_COPY       = 2'd0,
        MODE_ARGB_BLEND = 2'd1,
        MODE_MASK_BLEND = 2'd2,
        MODE_MASK_FILL  = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [1:0] REG_FILL_COLOR  = 2'd1;
    localparam logic [1:0] REG_MASK_LEVELS = 2'd2;

    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam logic [7:0]  CHAN_MAX = 8'hff;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] fill;
        logic [7:0]  scale;
    } cfg_t;

    // Item leaving the mask stages
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] src;
        logic [7:0]  mask;
        logic [7:0]  mfa;
    } mask_item_t;

    // Mask scale factor: largest k with k * levels <= 255; zero levels acts as one
    function automatic logic [7:0] scale_of(input logic [7:0] levels);
        logic [7:0] k;
        begin
            case (levels) inside
                8'd0, 8'd1:       k = 8'd255;
                8'd2:             k = 8'd127;
                8'd3:             k = 8'd85;
                8'd4:             k = 8'd63;
                8'd5:             k = 8'd51;
                8'd6:             k = 8'd42;
                8'd7:             k = 8'd36;
                8'd8:             k = 8'd31;
                8'd9:             k = 8'd28;
                8'd10:            k = 8'd25;
                8'd11:            k = 8'd23;
                8'd12:            k = 8'd21;
                8'd13:            k = 8'd19;
                8'd14:            k = 8'd18;
                8'd15:            k = 8'd17;
                [8'd16:8'd17]:    k = 8'd15;
                8'd18:            k = 8'd14;
                8'd19:            k = 8'd13;
                [8'd20:8'd21]:    k = 8'd12;
                [8'd22:8'd23]:    k = 8'd11;
                [8'd24:8'd25]:    k = 8'd10;
                [8'd26:8'd28]:    k = 8'd9;
                [8'd29:8'd31]:    k = 8'd8;
                [8'd32:8'd36]:    k = 8'd7;
                [8'd37:8'd42]:    k = 8'd6;
                [8'd43:8'd51]:    k = 8'd5;
                [8'd52:8'd63]:    k = 8'd4;
                [8'd64:8'd85]:    k = 8'd3;
                [8'd86:8'd127]:   k = 8'd2;
                default:          k = 8'd1;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            return sum[8] ? CHAN_MAX : sum[7:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/abpb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module abpb_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    output abpb_pkg::cfg_t           cfg
);

    abpb_pkg::mode_t mode_reg;
    logic [31:0]     fill_reg;
    logic [7:0]      scale_reg;

    // Look up the scale on the write so the datapath only sees a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= abpb_pkg::MODE_COPY;
            fill_reg  <= '0;
            scale_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abpb_pkg::REG_BLEND_MODE:  mode_reg  <= abpb_pkg::mode_t'(cfg_data[1:0]);
                abpb_pkg::REG_FILL_COLOR:  fill_reg  <= cfg_data;
                abpb_pkg::REG_MASK_LEVELS: scale_reg <= abpb_pkg::scale_of(cfg_data[7:0]);
                default:                   ;
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.fill  = fill_reg;
    assign cfg.scale = scale_reg;

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg != 8'd0)
        else $error("mask scale is zero");

    a_levels_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == abpb_pkg::REG_MASK_LEVELS && cfg_data[7:0] >= 8'd128
        |=> scale_reg == 8'd1)
        else $error("mask scale wrong for large mask levels");

endmodule

`default_nettype wire

### hw/rtl/abpb_mask.sv
`timescale 1ns / 1ps
`default_nettype none

module abpb_mask (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire abpb_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           dest_pixel,
    input  wire logic [31:0]           src_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output abpb_pkg::mask_item_t       out_item
);

    logic                 s1_valid_reg;
    logic [31:0]          s1_dest_reg;
    logic [31:0]          s1_src_reg;
    logic [7:0]           s1_mask_reg;
    logic                 s2_valid_reg;
    abpb_pkg::mask_item_t s2_item_reg;

    logic                 s1_ready;
    logic                 s2_ready;
    logic [15:0]          mask_prod;
    logic [7:0]           mask_next;
    logic [15:0]          mfa_prod;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    // Scale the mask byte and saturate
    assign mask_prod = {8'd0, src_value[7:0]} * {8'd0, cfg.scale};
    assign mask_next = (mask_prod[15:8] != 8'd0) ? abpb_pkg::CHAN_MAX : mask_prod[7:0];

    // Mask times fill alpha
    assign mfa_prod  = {8'd0, s1_mask_reg} * {8'd0, cfg.fill[31:24]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_dest_reg <= dest_pixel;
            s1_src_reg  <= src_value;
            s1_mask_reg <= mask_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg.dest <= s1_dest_reg;
            s2_item_reg.src  <= s1_src_reg;
            s2_item_reg.mask <= s1_mask_reg;
            s2_item_reg.mfa  <= mfa_prod[15:8];
        end
    end

    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted item did not enter the first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_item_reg))
        else $error("held mask item changed");

endmodule

`default_nettype wire

### hw/rtl/abpb_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module abpb_mix (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire abpb_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire abpb_pkg::mask_item_t  in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                out_pixel
);

    localparam int unsigned NCHAN = 3;

    logic        s3_valid_reg;
    logic [31:0] s3_src_reg;
    logic [7:0]  s3_mfa_reg;
    logic [7:0]  s3_alpha_reg;
    logic [15:0] s3_dprod_reg [NCHAN];
    logic [15:0] s3_sprod_reg [NCHAN];
    logic        s4_valid_reg;
    logic [31:0] s4_pixel_reg;

    logic        s3_ready;
    logic        s4_ready;
    logic [7:0]  dest_a;
    logic [7:0]  weight;
    logic [7:0]  alpha_next;
    logic [31:0] color;
    logic [15:0] dprod_next [NCHAN];
    logic [15:0] sprod_next [NCHAN];
    logic [16:0] chan_sum   [NCHAN];
    logic [23:0] rgb;
    logic [31:0] pixel_next;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;

    assign dest_a = in_item.dest[31:24];

    // Pick the colour weight; transparent destination takes the colour whole
    always_comb
    begin
        weight     = 8'd0;
        alpha_next = in_item.mfa;
        color      = cfg.fill;
        case (cfg.mode)
            abpb_pkg::MODE_ARGB_BLEND:
            begin
                color      = in_item.src;
                alpha_next = abpb_pkg::sat_add8(dest_a, in_item.src[31:24]);
                if (dest_a == 8'd0)
                    weight = abpb_pkg::CHAN_MAX;
                else
                    weight = in_item.src[31:24];
            end
            abpb_pkg::MODE_MASK_BLEND:
            begin
                alpha_next = abpb_pkg::sat_add8(dest_a, in_item.mfa);
                if (dest_a == 8'd0)
                    weight = abpb_pkg::CHAN_MAX;
                else if (in_item.mask == 8'd0)
                    weight = 8'd0;
                else
                    weight = in_item.mfa;
            end
            default:
            begin
                weight = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            dprod_next[c] = {8'd0, in_item.dest[c*8 +: 8]} * {8'd0, abpb_pkg::CHAN_MAX - weight};
            sprod_next[c] = {8'd0, color[c*8 +: 8]} * {8'd0, weight};
        end
    end

    // Sum stays below 255 * 256, so the high byte needs no saturation
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            chan_sum[c]      = {1'b0, s3_dprod_reg[c]} + {1'b0, s3_sprod_reg[c]};
            rgb[c*8 +: 8]    = chan_sum[c][15:8];
        end
    end

    always_comb
    begin
        case (cfg.mode)
            abpb_pkg::MODE_COPY:       pixel_next = s3_src_reg;
            abpb_pkg::MODE_MASK_FILL:  pixel_next = {s3_mfa_reg, cfg.fill[23:0]};
            default:                   pixel_next = {s3_alpha_reg, rgb};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_src_reg   <= in_item.src;
            s3_mfa_reg   <= in_item.mfa;
            s3_alpha_reg <= alpha_next;
            for (int c = 0; c < NCHAN; c++)
            begin
                s3_dprod_reg[c] <= dprod_next[c];
                s3_sprod_reg[c] <= sprod_next[c];
            end
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_pixel_reg <= pixel_next;
        end
    end

    assign in_ready  = s3_ready;
    assign out_valid = s4_valid_reg;
    assign out_pixel = s4_pixel_reg;

endmodule

`default_nettype wire

### hw/rtl/argb_blit_pixel_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel blend stage of a blit engine. Each transfer on the input carries the
// current destination pixel and a source value (an ARGB8888 pixel, or a mask in
// bits 7..0 in the mask modes); one output transfer returns the pixel to write.
// blend_mode selects copy, ARGB alpha blend, mask blend with fill_color, or mask
// fill; mask_levels sets the mask scale (255 / mask_levels, looked up on write).
// The datapath is a four-stage pipeline: mask scale, mask times fill alpha,
// weight select with channel products, then channel sums into the output
// register. Throughput is one pixel per cycle while out_stall is low; out_valid
// rises once the result has moved through the stage registers into the output
// register. in_stall rises only when all four stages hold data and out_stall is
// high. Write configuration only while the pipeline is empty.
module argb_blit_pixel_blend (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    // Pixel input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] dest_pixel,
    input  wire logic [31:0] src_value,

    // Pixel output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_pixel
);

    abpb_pkg::cfg_t       cfg;
    abpb_pkg::mask_item_t mask_item;
    logic                 mask_in_ready;
    logic                 mask_valid;
    logic                 mix_ready;

    // Register file and scale lookup
    abpb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages 1-2: scaled mask, mask times fill alpha
    abpb_mask u_mask (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (mask_in_ready),
        .dest_pixel (dest_pixel),
        .src_value  (src_value),
        .out_valid  (mask_valid),
        .out_ready  (mix_ready),
        .out_item   (mask_item)
    );

    // Stages 3-4: weight, channel products, sums and output register
    abpb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (mask_valid),
        .in_ready  (mix_ready),
        .in_item   (mask_item),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_pixel (out_pixel)
    );

    // Backpressure reaches the input only through a full pipeline
    assign in_stall = !mask_in_ready;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> mask_valid && out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

endmodule

`default_nettype wire

### verif/argb_blit_pixel_blend_test.sv
`timescale 1ns / 1ps

module argb_blit_pixel_blend_test;

    // The register port is two bits wide; index 3 names no register.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int unsigned RANDOM_PIXELS = 700;
    localparam int unsigned MAX_GAP       = 18;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned PIPE_DEPTH    = 4;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // One directed transfer: the configuration it runs under, the pixel pair
    // and, where it is obvious, the pixel that must come back.
    typedef struct packed {
        abpb_pkg::mode_t mode;
        logic [31:0]     fill;
        logic [7:0]      levels;
        logic [31:0]     dest;
        logic [31:0]     src;
        bit              known;
        logic [31:0]     result;
    } blit_case_t;

    localparam int unsigned NUM_CASES = 22;

    localparam blit_case_t DIRECTED [0:NUM_CASES-1] = '{
        // reset configuration: copy, no fill, full mask range
        '{abpb_pkg::MODE_COPY,       32'h00000000, 8'd255,
          32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
        '{abpb_pkg::MODE_COPY,       32'h00000000, 8'd255,
          32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
        '{abpb_pkg::MODE_COPY,       32'h00000000, 8'd255,
          32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1, 32'ha5a5a5a5},
        // mask fill with the reset fill colour writes all zero
        '{abpb_pkg::MODE_MASK_FILL,  32'h00000000, 8'd255,
          32'h12345678, 32'hffffffff, 1'b1, 32'h00000000},
        // alpha blend: transparent destination, transparent source, extremes
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'h00112233, 32'h80ffffff, 1'b0, 32'h0},
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'hff102030, 32'h00ffffff, 1'b0, 32'h0},
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'h80402010, 32'h80c0e0f0, 1'b0, 32'h0},
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'h00000000, 32'h00000000, 1'b0, 32'h0},
        '{abpb_pkg::MODE_ARGB_BLEND, 32'h00000000, 8'd255,
          32'h01ffffff, 32'hff000000, 1'b0, 32'h0},
        // mask blend: transparent destination, zero mask, mid mask
        '{abpb_pkg::MODE_MASK_BLEND, 32'h80ff8040, 8'd255,
          32'h00000000, 32'h000000ff, 1'b0, 32'h0},
        '{abpb_pkg::MODE_MASK_BLEND, 32'h80ff8040, 8'd255,
          32'hff00ff00, 32'hffffff00, 1'b0, 32'h0},
        '{abpb_pkg::MODE_MASK_BLEND, 32'h80ff8040, 8'd255,
          32'hff00ff00, 32'h00000080, 1'b0, 32'h0},
        // mask above the level count saturates, mask at the level count does not
        '{abpb_pkg::MODE_MASK_BLEND, 32'h80ff8040, 8'd4,
          32'h40804080, 32'h00000005, 1'b0, 32'h0},
        '{abpb_pkg::MODE_MASK_BLEND, 32'h80ff8040, 8'd4,
          32'h40804080, 32'h00000004, 1'b0, 32'h0},
        // zero level count scales like a count of one
        '{abpb_pkg::MODE_MASK_FILL,  32'hff123456, 8'd0,
          32'hdeadbeef, 32'h00000001, 1'b1, 32'hfe123456},
        '{abpb_pkg::MODE_MASK_FILL,  32'hff123456, 8'd0,
          32'hdeadbeef, 32'hffffff00, 1'b1, 32'h00123456},
        '{abpb_pkg::MODE_MASK_FILL,  32'hff123456, 8'd1,
          32'h00000000, 32'h000000ff, 1'b1, 32'hfe123456},
        '{abpb_pkg::MODE_MASK_FILL,  32'h00abcdef, 8'd255,
          32'hffffffff, 32'h000000ff, 1'b1, 32'h00abcdef},
        '{abpb_pkg::MODE_MASK_FILL,  32'hffffffff, 8'd255,
          32'h00000000, 32'hffffffff, 1'b1, 32'hfeffffff},
        '{abpb_pkg::MODE_MASK_BLEND, 32'hffffffff, 8'd1,
          32'h7f808080, 32'h00000001, 1'b0, 32'h0},
        '{abpb_pkg::MODE_COPY,       32'hffffffff, 8'd1,
          32'h12345678, 32'h87654321, 1'b1, 32'h87654321}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] dest_pixel;
    logic [31:0] src_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_pixel;

    // Shadow copy of the block's configuration, updated on every write
    abpb_pkg::mode_t cur_mode;
    logic [31:0]     cur_fill;
    logic [7:0]      cur_levels;
    logic [7:0]      cur_scale;

    // Pixels still owed by the block, oldest first
    logic [31:0] owed_pixels [$];

    int unsigned mismatches;
    int unsigned cycles;
    int unsigned pixels_sent;

    // Traffic shaping shared by the two sides
    bit steady;      // no idling on either side
    bit squeeze;     // receiver should do its long hold-off
    bit held;        // long hold-off done

    argb_blit_pixel_blend dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .dest_pixel (dest_pixel),
        .src_value  (src_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pixel  (out_pixel)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Pixel the block must write for one transfer under the given configuration.
    // Channels blend as (d * (255 - w) + s * w) >> 8 with weight w.
    function automatic logic [31:0] blend_pixel(input abpb_pkg::mode_t mode,
                                                input logic [31:0] fill,
                                                input logic [7:0] scale,
                                                input logic [31:0] dest,
                                                input logic [31:0] src);
        logic [7:0]  dest_a;
        logic [7:0]  src_a;
        logic [7:0]  fill_a;
        logic [15:0] prod;
        logic [7:0]  mask;
        logic [7:0]  mask_a;
        logic [7:0]  weight;
        logic [8:0]  alpha_sum;
        logic [31:0] over;
        logic [16:0] acc;
        logic [31:0] pixel;
        int          ch;
        begin
            dest_a = dest[31:24];
            src_a  = src[31:24];
            fill_a = fill[31:24];
            prod   = src[7:0] * scale;
            mask   = (prod > 16'd255) ? 8'hff : prod[7:0];
            prod   = mask * fill_a;
            mask_a = prod[15:8];

            case (mode)
                abpb_pkg::MODE_COPY:
                    return src;
                abpb_pkg::MODE_MASK_FILL:
                    return {mask_a, fill[23:0]};
                abpb_pkg::MODE_ARGB_BLEND:
                begin
                    // transparent destination takes the source whole,
                    // transparent source puts the whole weight on the destination
                    weight    = (dest_a == 8'd0) ? 8'hff : src_a;
                    over      = src;
                    alpha_sum = {1'b0, dest_a} + {1'b0, src_a};
                end
                default:
                begin
                    if (dest_a == 8'd0)
                        weight = 8'hff;
                    else if (mask == 8'd0)
                        weight = 8'd0;
                    else
                        weight = mask_a;
                    over      = fill;
                    alpha_sum = {1'b0, dest_a} + {1'b0, mask_a};
                end
            endcase

            pixel[31:24] = alpha_sum[8] ? 8'hff : alpha_sum[7:0];
            for (ch = 0; ch < 3; ch++)
            begin
                acc = dest[8*ch +: 8] * (8'd255 - weight) + over[8*ch +: 8] * weight;
                pixel[8*ch +: 8] = (acc[16:8] > 9'd255) ? 8'hff : acc[15:8];
            end
            return pixel;
        end
    endfunction

    // Write one register and track it in the shadow copy. Call only while idle.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= index;
            cfg_data  <= data;
            @(negedge clk);
            cfg_we    <= 1'b0;
            case (index)
                abpb_pkg::REG_BLEND_MODE:  cur_mode = abpb_pkg::mode_t'(data[1:0]);
                abpb_pkg::REG_FILL_COLOR:  cur_fill = data;
                abpb_pkg::REG_MASK_LEVELS:
                begin
                    cur_levels = data[7:0];
                    cur_scale  = (data[7:0] == 8'd0) ? 8'd255 : 8'd255 / data[7:0];
                end
                default: ;
            endcase
        end
    endtask

    // Drop valid, let every owed pixel come back, then let the pipeline drain.
    task automatic wait_pipeline_empty;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (owed_pixels.size() != 0)
                @(posedge clk);
            repeat (PIPE_DEPTH) @(posedge clk);
        end
    endtask

    // Offer one pixel pair after a random gap, or none when steady; owe the
    // given pixel once the transfer happens.
    task automatic send_pixel(input logic [31:0] dest, input logic [31:0] src,
                              input logic [31:0] pixel);
        int unsigned gap;
        begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) @(negedge clk) in_valid <= 1'b0;
            @(negedge clk);
            in_valid   <= 1'b1;
            dest_pixel <= dest;
            src_value  <= src;
            do
                @(posedge clk);
            while (in_stall !== 1'b0);
            owed_pixels.push_back(pixel);
            pixels_sent++;
        end
    endtask

    // Alpha byte biased toward the special values
    function automatic logic [7:0] pick_alpha();
        begin
            case ($urandom_range(0, 4))
                0:       return 8'h00;
                1:       return 8'hff;
                default: return 8'($urandom);
            endcase
        end
    endfunction

    // Mask byte biased toward zero, the level count and just above it
    function automatic logic [7:0] pick_mask();
        begin
            case ($urandom_range(0, 5))
                0:       return 8'h00;
                1:       return cur_levels;
                2:       return cur_levels + 8'd1;
                3:       return 8'hff;
                default: return 8'($urandom);
            endcase
        end
    endfunction

    // Receiver: stall for a random count before each transfer, once hold off
    // long enough that the pipeline fills and pushes back on the input.
    initial
    begin
        int unsigned gap;
        logic [31:0] want;
        @(posedge rst_n);
        forever
        begin
            if (squeeze && !held)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            else
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) @(negedge clk) out_stall <= 1'b1;
            @(negedge clk) out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);

            if (owed_pixels.size() == 0)
            begin
                $error("out_pixel %08h arrived with no pixel owed", out_pixel);
                mismatches++;
            end
            else
            begin
                want = owed_pixels.pop_front();
                if (out_pixel !== want)
                begin
                    $error("out_pixel mismatch: expected %08h, actual %08h", want, out_pixel);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, verdict
    initial
    begin
        blit_case_t  row;
        logic [31:0] want;
        logic [31:0] data;
        logic [31:0] dest;
        logic [31:0] src;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned i;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = abpb_pkg::REG_BLEND_MODE;
        cfg_data    = 32'h0;
        in_valid    = 1'b0;
        dest_pixel  = 32'h0;
        src_value   = 32'h0;
        out_stall   = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        pixels_sent = 0;
        steady      = 1'b0;
        squeeze     = 1'b0;
        held        = 1'b0;
        cur_mode    = abpb_pkg::MODE_COPY;
        cur_fill    = 32'h0;
        cur_levels  = 8'd255;
        cur_scale   = 8'd1;

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // A write to the unused index must leave the reset configuration alone.
        write_reg(REG_SPARE, 32'hffffffff);

        // Directed table: reconfigure only when a row asks for something new
        for (i = 0; i < NUM_CASES; i++)
        begin
            row = DIRECTED[i];
            if (row.mode != cur_mode || row.fill != cur_fill || row.levels != cur_levels)
            begin
                wait_pipeline_empty();
                if (row.mode != cur_mode)
                    write_reg(abpb_pkg::REG_BLEND_MODE, {30'h0, row.mode});
                if (row.fill != cur_fill)
                    write_reg(abpb_pkg::REG_FILL_COLOR, row.fill);
                if (row.levels != cur_levels)
                    write_reg(abpb_pkg::REG_MASK_LEVELS, {24'h0, row.levels});
            end
            want = row.known ? row.result
                             : blend_pixel(cur_mode, cur_fill, cur_scale, row.dest, row.src);
            send_pixel(row.dest, row.src, want);
        end

        // Random phases: fresh configuration each phase, written with junk in
        // the unused upper bits; the third phase carries the long hold-off.
        phase = 0;
        while (pixels_sent < NUM_CASES + RANDOM_PIXELS)
        begin
            wait_pipeline_empty();
            steady  = 1'b0;
            squeeze = 1'b0;

            data      = $urandom;
            data[1:0] = 2'($urandom_range(0, 3));
            write_reg(abpb_pkg::REG_BLEND_MODE, data);

            case ($urandom_range(0, 5))
                0:       data = 32'h00000000;
                1:       data = 32'hffffffff;
                2:       data = {8'hff, 24'($urandom)};
                default: data = $urandom;
            endcase
            write_reg(abpb_pkg::REG_FILL_COLOR, data);

            data = $urandom;
            case ($urandom_range(0, 6))
                0:       data[7:0] = 8'd0;
                1:       data[7:0] = 8'd1;
                2:       data[7:0] = 8'd255;
                3:       data[7:0] = 8'($urandom_range(2, 16));
                default: data[7:0] = 8'($urandom_range(1, 255));
            endcase
            write_reg(abpb_pkg::REG_MASK_LEVELS, data);

            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom);

            phase_len = $urandom_range(20, 90);
            if (phase == 2)
            begin
                // keep the input busy while the receiver holds off
                steady    = 1'b1;
                squeeze   = 1'b1;
                phase_len = 60;
            end
            else if ($urandom_range(0, 3) == 0)
                steady = 1'b1;

            repeat (phase_len)
            begin
                dest = $urandom;
                src  = $urandom;
                dest[31:24] = pick_alpha();
                if (cur_mode == abpb_pkg::MODE_MASK_BLEND ||
                    cur_mode == abpb_pkg::MODE_MASK_FILL)
                    src[7:0] = pick_mask();
                else
                    src[31:24] = pick_alpha();
                send_pixel(dest, src, blend_pixel(cur_mode, cur_fill, cur_scale, dest, src));
            end
            phase++;
        end

        // Collect the tail and give any stray output time to show up.
        steady  = 1'b0;
        squeeze = 1'b0;
        wait_pipeline_empty();
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
